// ===== hdl/cse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cse_pkg
// Types and character constants shared by the string literal escaper.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int MAX_CHARS = 10;
    localparam int CNT_W     = 4;
    localparam int BREAK_LEN = 5;

    localparam logic [9:0] MIN_LIMIT   = 10'd5;
    localparam logic [9:0] LIMIT_RESET = 10'd180;

    // configuration register indexes
    localparam logic [3:0] CFG_LINE_LIMIT = 4'd0;
    localparam logic [3:0] CFG_HEX_UPPER  = 4'd1;

    // item kinds
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    localparam logic [BREAK_LEN-1:0][7:0] BREAK_SEQ =
        {CH_QUOTE, CH_TAB, CH_LF, CH_CR, CH_QUOTE};

    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [CNT_W-1:0]          count;
        logic                      is_end;
    } cse_burst_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UPPER_A : CH_LOWER_A;
        if (nib < 4'd10) begin
            hex_digit = CH_ZERO + {4'd0, nib};
        end else begin
            hex_digit = base + {4'd0, nib} - 8'd10;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/c_string_literal_escaper_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c_string_literal_escaper_unit
// Turns a byte stream into the text of one quoted, escaped, wrapped C string
// literal.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per content byte (s_tuser = 0) or one end request
//   (s_tuser = 1) that closes the literal. m_ channel: one character per
//   transfer; m_tlast marks the last character of a request, m_tuser the
//   closing quote. cfg channel writes line_limit (index 0) and hex_uppercase
//   (index 1); it is always ready. The user must write it only while the
//   block is idle; the block itself does not enforce this. A request's first
//   character passes through the burst register, then the output register.
//   A request of k characters (1 to 10) plays them out in order; plain bytes
//   mid-line go at one per cycle while m_tready is high. A request is taken
//   in the cycle its predecessor's last character enters the output register.
//   Reset: synchronous, active low; clears the line count, the open-quote flag,
//   the burst in flight and the output valid, and loads line_limit = 180 and
//   hex_uppercase = 1.
//   Stall: while m_tready is low the output character holds; s_tready stays
//   low while a burst waits behind it, so at most one more request is taken.
// ----------------------------------------------------------------------------
module c_string_literal_escaper_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_char
    output logic             m_tlast,
    output logic             m_tuser,   // [0] literal_done
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [9:0]  cfg_data
);

    logic [9:0]              line_limit_reg;
    logic                    hex_upper_reg;
    logic                    s_accept;
    cse_pkg::cse_burst_t     burst;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_limit_reg <= cse_pkg::LIMIT_RESET;
            hex_upper_reg  <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cse_pkg::CFG_LINE_LIMIT: line_limit_reg <= cfg_data;
                cse_pkg::CFG_HEX_UPPER:  hex_upper_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    cse_encoder u_encoder (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (s_accept),
        .action        (s_tuser),
        .data_byte     (s_tdata),
        .line_limit    (line_limit_reg),
        .hex_uppercase (hex_upper_reg),
        .burst         (burst)
    );

    cse_emitter u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s_accept),
        .burst    (burst),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

// ===== hdl/cse_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cse_encoder
// Expands one request into its burst of literal characters and keeps the
// line count and open-quote state.
// ----------------------------------------------------------------------------
module cse_encoder (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic              action,
    input  wire logic [7:0]        data_byte,
    input  wire logic [9:0]        line_limit,
    input  wire logic              hex_uppercase,
    output cse_pkg::cse_burst_t    burst
);

    logic [9:0]                    line_count_reg, line_count_next;
    logic                          open_reg, open_next;

    logic [9:0]                    lim;
    logic                          esc;
    logic [7:0]                    short_ch;
    logic [10:0]                   esc_len;
    logic [10:0]                   lc;
    logic [cse_pkg::CNT_W-1:0]     n;
    logic [cse_pkg::MAX_CHARS-1:0][7:0] chars;

    always_comb begin
        lim = (line_limit < cse_pkg::MIN_LIMIT) ? cse_pkg::MIN_LIMIT : line_limit;
        esc = (data_byte < cse_pkg::CH_SPACE) || (data_byte >= cse_pkg::CH_DEL) ||
              (data_byte == cse_pkg::CH_QUOTE) || (data_byte == cse_pkg::CH_BSLASH);
        case (data_byte)
            cse_pkg::CH_NUL:    short_ch = cse_pkg::CH_ZERO;
            cse_pkg::CH_TAB:    short_ch = cse_pkg::CH_T;
            cse_pkg::CH_LF:     short_ch = cse_pkg::CH_N;
            cse_pkg::CH_CR:     short_ch = cse_pkg::CH_R;
            cse_pkg::CH_QUOTE:  short_ch = cse_pkg::CH_QUOTE;
            cse_pkg::CH_BSLASH: short_ch = cse_pkg::CH_BSLASH;
            default:            short_ch = cse_pkg::CH_NUL;
        endcase
        esc_len = (short_ch != cse_pkg::CH_NUL) ? 11'd2 : 11'd4;
    end

    always_comb begin
        chars     = '0;
        n         = '0;
        lc        = {1'b0, line_count_reg};
        open_next = open_reg;

        if (!open_reg) begin
            chars[n] = cse_pkg::CH_QUOTE;
            n        = n + 4'd1;
        end

        if (action == cse_pkg::ACT_END) begin
            chars[n]  = cse_pkg::CH_QUOTE;
            n         = n + 4'd1;
            lc        = '0;
            open_next = 1'b0;
        end else if (!esc) begin
            chars[n]  = data_byte;
            n         = n + 4'd1;
            lc        = lc + 11'd1;
            open_next = 1'b1;
            if (lc >= {1'b0, lim}) begin
                for (int j = 0; j < cse_pkg::BREAK_LEN; j++) begin
                    chars[n + 4'(j)] = cse_pkg::BREAK_SEQ[j];
                end
                n  = n + 4'(cse_pkg::BREAK_LEN);
                lc = '0;
            end
        end else begin
            open_next = 1'b1;
            // wrap first when the whole escape would not fit on this line
            if (lc + esc_len > {1'b0, lim}) begin
                for (int j = 0; j < cse_pkg::BREAK_LEN; j++) begin
                    chars[n + 4'(j)] = cse_pkg::BREAK_SEQ[j];
                end
                n  = n + 4'(cse_pkg::BREAK_LEN);
                lc = '0;
            end
            chars[n] = cse_pkg::CH_BSLASH;
            n        = n + 4'd1;
            if (short_ch != cse_pkg::CH_NUL) begin
                chars[n] = short_ch;
                n        = n + 4'd1;
            end else begin
                chars[n]        = cse_pkg::CH_X;
                chars[n + 4'd1] = cse_pkg::hex_digit(data_byte[7:4], hex_uppercase);
                chars[n + 4'd2] = cse_pkg::hex_digit(data_byte[3:0], hex_uppercase);
                n               = n + 4'd3;
            end
            lc = lc + esc_len;
            if (lc >= {1'b0, lim}) begin
                for (int j = 0; j < cse_pkg::BREAK_LEN; j++) begin
                    chars[n + 4'(j)] = cse_pkg::BREAK_SEQ[j];
                end
                n  = n + 4'(cse_pkg::BREAK_LEN);
                lc = '0;
            end
        end

        line_count_next = lc[9:0];
    end

    assign burst = '{chars: chars, count: n, is_end: (action == cse_pkg::ACT_END)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_count_reg <= '0;
            open_reg       <= 1'b0;
        end else if (accept) begin
            line_count_reg <= line_count_next;
            open_reg       <= open_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/cse_emitter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cse_emitter
// Holds one character burst and plays it out through the output register,
// one character per cycle while m_tready does not stall it.
// ----------------------------------------------------------------------------
module cse_emitter (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire cse_pkg::cse_burst_t burst,
    output logic                   in_ready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser
);

    cse_pkg::cse_burst_t           burst_reg;
    logic                          busy_reg;
    logic [cse_pkg::CNT_W-1:0]     idx_reg;
    logic                          m_valid_reg;
    logic [7:0]                    m_data_reg;
    logic                          m_last_reg;
    logic                          m_done_reg;

    logic                          out_load;
    logic                          last_slot;

    assign out_load  = busy_reg && (!m_valid_reg || m_tready);
    assign last_slot = (idx_reg == burst_reg.count - 4'd1);
    // next request may enter while the last character moves out
    assign in_ready  = !busy_reg || (out_load && last_slot);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (out_load) begin
                idx_reg <= idx_reg + 4'd1;
                if (last_slot) begin
                    busy_reg <= 1'b0;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            burst_reg <= burst;
        end
        if (out_load) begin
            m_data_reg <= burst_reg.chars[idx_reg];
            m_last_reg <= last_slot;
            m_done_reg <= last_slot && burst_reg.is_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_done_reg;

endmodule
`default_nettype wire

// ===== hdl/cse_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cse_checker
// Port-level checks for the string literal escaper, bound to the top level.
// ----------------------------------------------------------------------------
module cse_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic       m_tuser
);

    // closing quote always ends its request
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("literal_done without run_last");

    a_done_is_quote: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == cse_pkg::CH_QUOTE))
        else $error("literal_done on a character other than a quote");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("output changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind c_string_literal_escaper_unit cse_checker u_cse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for c_string_literal_escaper_unit: drives content and
// end requests, predicts every literal character and compares it per field.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic       act;
        logic [7:0] data;
    } byte_req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       done;
    } lit_char_t;

    // index with no register behind it
    localparam logic [3:0] CFG_UNUSED = 4'd15;

    localparam logic [7:0] SPECIALS [6] = '{cse_pkg::CH_NUL, cse_pkg::CH_TAB,
        cse_pkg::CH_LF, cse_pkg::CH_CR, cse_pkg::CH_QUOTE, cse_pkg::CH_BSLASH};

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'd0;   // [7:0] data_byte
    logic       s_tuser   = 1'b0;   // [0] action
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_char
    logic       m_tlast;
    logic       m_tuser;            // [0] literal_done
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [3:0] cfg_index = 4'd0;
    logic [9:0] cfg_data  = 10'd0;

    c_string_literal_escaper_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    byte_req_t  byte_reqs[$];
    lit_char_t  expected_chars[$];
    int         queued_cnt   = 0;
    int         accepted_cnt = 0;
    int         fail_cnt     = 0;
    bit         idle_on      = 1'b1;
    int         s_gap        = 0;
    int         m_gap        = 0;

    // predictor state and register copies
    logic [9:0] limit_q        = cse_pkg::LIMIT_RESET;
    logic       hex_up_q       = 1'b1;
    int         line_cnt_q     = 0;
    logic       literal_open_q = 1'b0;

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void put_char(input logic [7:0] c, input logic d);
        lit_char_t e;
        e.ch   = c;
        e.last = 1'b0;
        e.done = d;
        expected_chars.push_back(e);
    endfunction

    function automatic void put_break();
        put_char(cse_pkg::CH_QUOTE, 1'b0);
        put_char(cse_pkg::CH_CR, 1'b0);
        put_char(cse_pkg::CH_LF, 1'b0);
        put_char(cse_pkg::CH_TAB, 1'b0);
        put_char(cse_pkg::CH_QUOTE, 1'b0);
        line_cnt_q = 0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return cse_pkg::CH_ZERO + 8'(n);
        return (hex_up_q ? cse_pkg::CH_UPPER_A : cse_pkg::CH_LOWER_A) + 8'(n) - 8'd10;
    endfunction

    // expected literal text for one accepted request
    function automatic void encode_item(input logic act, input logic [7:0] b);
        int         lim;
        int         len;
        logic [7:0] esc;
        lim = (limit_q < cse_pkg::MIN_LIMIT) ? int'(cse_pkg::MIN_LIMIT) : int'(limit_q);
        if (!literal_open_q) begin
            put_char(cse_pkg::CH_QUOTE, 1'b0);
            literal_open_q = 1'b1;
        end
        if (act == cse_pkg::ACT_END) begin
            put_char(cse_pkg::CH_QUOTE, 1'b1);
            line_cnt_q     = 0;
            literal_open_q = 1'b0;
        end else if (!(b < cse_pkg::CH_SPACE || b >= cse_pkg::CH_DEL ||
                       b == cse_pkg::CH_QUOTE || b == cse_pkg::CH_BSLASH)) begin
            put_char(b, 1'b0);
            line_cnt_q++;
            if (line_cnt_q >= lim) put_break();
        end else begin
            case (b)
                cse_pkg::CH_NUL:    esc = cse_pkg::CH_ZERO;
                cse_pkg::CH_TAB:    esc = cse_pkg::CH_T;
                cse_pkg::CH_LF:     esc = cse_pkg::CH_N;
                cse_pkg::CH_CR:     esc = cse_pkg::CH_R;
                cse_pkg::CH_QUOTE:  esc = cse_pkg::CH_QUOTE;
                cse_pkg::CH_BSLASH: esc = cse_pkg::CH_BSLASH;
                default:            esc = 8'd0;
            endcase
            len = (esc != 8'd0) ? 2 : 4;
            // escapes never split across a line break
            if (line_cnt_q + len > lim) put_break();
            put_char(cse_pkg::CH_BSLASH, 1'b0);
            if (esc != 8'd0) begin
                put_char(esc, 1'b0);
            end else begin
                put_char(cse_pkg::CH_X, 1'b0);
                put_char(hex_char(b[7:4]), 1'b0);
                put_char(hex_char(b[3:0]), 1'b0);
            end
            line_cnt_q += len;
            if (line_cnt_q >= lim) put_break();
        end
        line_cnt_q &= 'h3FF;
        expected_chars[expected_chars.size() - 1].last = 1'b1;
    endfunction

    always @(posedge aclk) begin : drive_s
        byte_req_t nxt;
        logic      nv;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap = 0;
        end else begin
            nv  = s_tvalid;
            nxt = {s_tuser, s_tdata};
            if (s_tvalid && s_tready) begin
                encode_item(s_tuser, s_tdata);
                accepted_cnt++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (s_gap > 0) begin
                    s_gap--;
                end else if (byte_reqs.size() > 0) begin
                    nxt   = byte_reqs.pop_front();
                    nv    = 1'b1;
                    s_gap = pick_gap();
                end
            end
            s_tvalid <= nv;
            s_tuser  <= nxt.act;
            s_tdata  <= nxt.data;
        end
    end

    always @(posedge aclk) begin : watch_m
        lit_char_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    $error("out_char: nothing expected, actual %h", m_tdata);
                    fail_cnt++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== want.ch) begin
                        $error("out_char: expected %h, actual %h", want.ch, m_tdata);
                        fail_cnt++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("run_last: expected %b, actual %b", want.last, m_tlast);
                        fail_cnt++;
                    end
                    if (m_tuser !== want.done) begin
                        $error("literal_done: expected %b, actual %b", want.done, m_tuser);
                        fail_cnt++;
                    end
                end
                m_gap = pick_gap();
            end
            if (m_gap > 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_item(input logic act, input logic [7:0] b);
        byte_req_t r;
        r.act  = act;
        r.data = b;
        byte_reqs.push_back(r);
        queued_cnt++;
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (accepted_cnt != queued_cnt || expected_chars.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [9:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == cse_pkg::CFG_LINE_LIMIT) limit_q = val;
        else if (idx == cse_pkg::CFG_HEX_UPPER) hex_up_q = val[0];
        @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 8'($urandom_range(32, 126));
        if (r < 7) return SPECIALS[$urandom_range(0, 5)];
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin : stimulus
        int lim;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every escape class at reset settings, then an empty literal
        queue_item(cse_pkg::ACT_BYTE, 8'h41);
        queue_item(cse_pkg::ACT_BYTE, cse_pkg::CH_SPACE);
        queue_item(cse_pkg::ACT_BYTE, 8'h7E);
        queue_item(cse_pkg::ACT_BYTE, cse_pkg::CH_NUL);
        queue_item(cse_pkg::ACT_BYTE, cse_pkg::CH_TAB);
        queue_item(cse_pkg::ACT_BYTE, cse_pkg::CH_LF);
        queue_item(cse_pkg::ACT_BYTE, cse_pkg::CH_CR);
        queue_item(cse_pkg::ACT_BYTE, cse_pkg::CH_QUOTE);
        queue_item(cse_pkg::ACT_BYTE, cse_pkg::CH_BSLASH);
        queue_item(cse_pkg::ACT_BYTE, 8'h1F);
        queue_item(cse_pkg::ACT_BYTE, cse_pkg::CH_DEL);
        queue_item(cse_pkg::ACT_BYTE, 8'h80);
        queue_item(cse_pkg::ACT_BYTE, 8'hFF);
        queue_item(cse_pkg::ACT_BYTE, 8'hAB);
        queue_item(cse_pkg::ACT_END, 8'hFF);
        queue_item(cse_pkg::ACT_END, 8'h00);
        wait_drained();

        // tightest line: breaks before escapes and after a full line, lower hex
        write_reg(cse_pkg::CFG_HEX_UPPER, 10'd0);
        write_reg(cse_pkg::CFG_LINE_LIMIT, 10'd5);
        queue_item(cse_pkg::ACT_BYTE, 8'h61);
        queue_item(cse_pkg::ACT_BYTE, 8'h62);
        queue_item(cse_pkg::ACT_BYTE, 8'h63);
        queue_item(cse_pkg::ACT_BYTE, 8'h01);
        queue_item(cse_pkg::ACT_BYTE, cse_pkg::CH_TAB);
        queue_item(cse_pkg::ACT_BYTE, 8'hFE);
        queue_item(cse_pkg::ACT_BYTE, 8'h7A);
        queue_item(cse_pkg::ACT_BYTE, 8'hCD);
        queue_item(cse_pkg::ACT_END, 8'h5A);
        wait_drained();

        // limit lowered while the line is long: escape first, then plain byte
        write_reg(cse_pkg::CFG_HEX_UPPER, 10'd1);
        write_reg(cse_pkg::CFG_LINE_LIMIT, 10'd1023);
        for (int i = 0; i < 30; i++) begin
            queue_item(cse_pkg::ACT_BYTE, 8'($urandom_range(32, 126)));
        end
        wait_drained();
        write_reg(cse_pkg::CFG_LINE_LIMIT, 10'd0);
        write_reg(CFG_UNUSED, 10'h3FF);
        queue_item(cse_pkg::ACT_BYTE, cse_pkg::CH_QUOTE);
        queue_item(cse_pkg::ACT_BYTE, 8'h71);
        wait_drained();
        write_reg(cse_pkg::CFG_LINE_LIMIT, 10'd1023);
        for (int i = 0; i < 10; i++) begin
            queue_item(cse_pkg::ACT_BYTE, 8'($urandom_range(32, 126)));
        end
        wait_drained();
        write_reg(cse_pkg::CFG_LINE_LIMIT, 10'd7);
        queue_item(cse_pkg::ACT_BYTE, 8'h4B);
        queue_item(cse_pkg::ACT_END, 8'h00);
        wait_drained();

        for (int p = 0; p < 7; p++) begin
            case (p)
                0:       lim = 5;
                1:       lim = 1023;
                2:       lim = 0;
                3:       lim = 6;
                4:       lim = cse_pkg::LIMIT_RESET;
                5:       lim = $urandom_range(5, 40);
                default: lim = $urandom_range(0, 1023);
            endcase
            write_reg(cse_pkg::CFG_LINE_LIMIT, 10'(lim));
            write_reg(cse_pkg::CFG_HEX_UPPER, 10'($urandom_range(0, 1)));
            // one phase runs back to back on both sides
            idle_on = (p != 3);
            for (int i = 0; i < 36; i++) begin
                // sender holds off until the block has fully drained
                if (i == 20) wait_drained();
                if ($urandom_range(0, 11) == 0) begin
                    queue_item(cse_pkg::ACT_END, 8'($urandom_range(0, 255)));
                end else begin
                    queue_item(cse_pkg::ACT_BYTE, rand_byte());
                end
            end
            wait_drained();
        end
        queue_item(cse_pkg::ACT_END, 8'h00);
        wait_drained();
        repeat (20) @(posedge aclk);

        if (fail_cnt == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin : watchdog
        #15_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/cse_pkg.sv
hdl/cse_encoder.sv
hdl/cse_emitter.sv
hdl/c_string_literal_escaper_unit.sv
hdl/cse_checker.sv
sim/tb.sv
